>>> rtl/rcdc_pkg.sv
// shared types, constants and table builders for the rabin content-defined chunker
`timescale 1ns / 1ps

package rcdc_pkg;

  // fingerprint width equals the degree of the reduction polynomial
  localparam int unsigned FP_W = 53;
  localparam logic [63:0] RABIN_POLY = 64'h003D_A335_8B4D_C173;

  localparam int unsigned LEN_W = 16;
  localparam int unsigned POS_W = 32;
  localparam int unsigned AVG_W = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEN_W-1:0] MIN_SIZE_RST = 16'd4096;
  localparam logic [LEN_W-1:0] MAX_SIZE_RST = 16'd16384;
  localparam logic [AVG_W-1:0] AVG_BITS_RST = 5'd13;

  // window content after reset and after every chunk boundary
  localparam logic [7:0] WIN_SEED_BYTE = 8'h01;
  localparam logic [FP_W-1:0] FP_SEED = 53'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SIZE = 2'd0,
    CFG_MAX_SIZE = 2'd1,
    CFG_AVG_BITS = 2'd2
  } cfg_idx_e;

  typedef logic [FP_W-1:0] fp_t;
  typedef logic [255:0][FP_W-1:0] fp_rom_t;

  typedef struct packed {
    logic shift;  // a byte enters the window
    logic init;   // window goes back to its seed content
  } win_ctrl_t;

  // remainder of x modulo the reduction polynomial over gf(2)
  function automatic logic [63:0] poly_mod(input logic [63:0] x);
    logic [63:0] r;
    r = x;
    for (int k = 63; k >= int'(FP_W); k--) begin
      if (r[k]) begin
        r = r ^ (RABIN_POLY << (k - int'(FP_W)));
      end
    end
    return r;
  endfunction

  // contribution of a byte that has sat win-1 positions deep in the window
  function automatic fp_rom_t build_slide_rom(input int unsigned win);
    fp_rom_t rom;
    logic [63:0] h;
    for (int b = 0; b < 256; b++) begin
      h = poly_mod(64'(b));
      for (int unsigned i = 0; i + 1 < win; i++) begin
        h = poly_mod(h << 8);
      end
      rom[b] = h[FP_W-1:0];
    end
    return rom;
  endfunction

  // fold of the eight bits shifted out above the fingerprint
  function automatic fp_rom_t build_reduce_rom();
    fp_rom_t rom;
    logic [63:0] h;
    for (int b = 0; b < 256; b++) begin
      h = poly_mod(64'(b) << FP_W);
      rom[b] = h[FP_W-1:0];
    end
    return rom;
  endfunction

  localparam fp_rom_t REDUCE_ROM = build_reduce_rom();

endpackage

>>> rtl/rabin_content_defined_chunker.sv
// result: registered with the closing byte's transaction, valid in the cycle after
// throughput: one byte per cycle; the window cells, the fingerprint and the boundary
//   test all settle in the cycle of the transaction; input stalls only while a result
//   waits in the output register with out_ready_i low
// reset: asynchronous, active low; window seeded with byte 1 in cell 0 and zeros behind,
//   fingerprint 1, counters 0, size registers 4096 / 16384 / 13, output empty
`timescale 1ns / 1ps

module rabin_content_defined_chunker import rcdc_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  // byte stream
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  // chunk results
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [POS_W-1:0]      chunk_start_o,
  output logic [LEN_W-1:0]      chunk_length_o,
  output logic [FP_W-1:0]       cut_fingerprint_o,
  output logic                  at_stream_end_o
);

  // configuration registers
  logic [LEN_W-1:0] min_size_q, max_size_q;
  logic [AVG_W-1:0] avg_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= MIN_SIZE_RST;
      max_size_q <= MAX_SIZE_RST;
      avg_bits_q <= AVG_BITS_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MIN_SIZE: min_size_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_MAX_SIZE: max_size_q <= cfg_wdata_i[LEN_W-1:0];
        CFG_AVG_BITS: avg_bits_q <= cfg_wdata_i[AVG_W-1:0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // handshake: the output register frees up in the same cycle it is taken
  logic out_valid_q, out_valid_d;
  logic accept;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // counters
  logic [LEN_W-1:0] cnt_q, cnt_d, cnt_inc;
  logic [POS_W-1:0] pos_q, pos_d, pos_inc;
  logic [POS_W-1:0] begin_q, begin_d;

  // boundary decision
  fp_t       fp_step;
  fp_t       fp_mask;
  logic      fp_hit;
  logic      cut;
  logic      emit;
  win_ctrl_t win_ctrl;

  assign cnt_inc = cnt_q + LEN_W'(1);
  assign pos_inc = pos_q + POS_W'(1);

  always_comb begin
    fp_mask = ~({FP_W{1'b1}} << avg_bits_q);
    fp_hit  = (fp_step & fp_mask) == '0;
    cut     = ((cnt_inc >= min_size_q) && fp_hit) || (cnt_inc >= max_size_q);
    emit    = accept && (cut || last_byte_i);
  end

  assign win_ctrl.shift = accept;
  assign win_ctrl.init  = emit;

  // window shift line: cell 0 holds the newest byte, the last cell the oldest
  logic [7:0] win [WINDOW_SIZE];

  for (genvar gi = 0; gi < WINDOW_SIZE; gi++) begin : g_cell
    if (gi == 0) begin : g_head
      rcdc_window_cell #(
        .SEED (WIN_SEED_BYTE)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (win_ctrl),
        .prev_i (data_byte_i),
        .byte_o (win[gi])
      );
    end else begin : g_body
      rcdc_window_cell #(
        .SEED (8'h00)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctrl_i (win_ctrl),
        .prev_i (win[gi-1]),
        .byte_o (win[gi])
      );
    end
  end

  // the byte one cell short of the tail is the one that leaves on the next transaction,
  // so its slide-out term is registered as it moves to the tail; the tail is not read
  rcdc_fp_unit #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_fp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (win_ctrl),
    .byte_i       (data_byte_i),
    .next_leave_i (win[WINDOW_SIZE-2]),
    .fp_step_o    (fp_step)
  );

  always_comb begin
    cnt_d   = cnt_q;
    pos_d   = pos_q;
    begin_d = begin_q;
    if (accept) begin
      cnt_d = emit ? '0 : cnt_inc;
      if (emit) begin
        begin_d = pos_inc;
      end
      pos_d = pos_inc;
      // end of stream restarts the offsets for the next stream
      if (last_byte_i) begin
        pos_d   = '0;
        begin_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      pos_q   <= '0;
      begin_q <= '0;
    end else begin
      cnt_q   <= cnt_d;
      pos_q   <= pos_d;
      begin_q <= begin_d;
    end
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      chunk_start_o     <= begin_q;
      chunk_length_o    <= cnt_inc;
      cut_fingerprint_o <= fp_step;
      at_stream_end_o   <= !cut;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // offsets and length counter always agree on where the open chunk began
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q - begin_q) == POS_W'(cnt_q))
    else $error("chunk begin, position and length out of step");

  // a final byte always restarts the stream offsets and the open chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_byte_i) |=> (pos_q == '0) && (begin_q == '0) && (cnt_q == '0))
    else $error("stream end did not restart the counters");

  // a result never carries an empty chunk
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (chunk_length_o != '0))
    else $error("empty chunk emitted");

  // a content cut meets the size and fingerprint rule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !at_stream_end_o) |->
      ((chunk_length_o >= max_size_q) ||
       ((chunk_length_o >= min_size_q) && ((cut_fingerprint_o & fp_mask) == '0))))
    else $error("cut emitted without a boundary");
`endif

endmodule

>>> rtl/rcdc_window_cell.sv
// one byte cell of the sliding window shift line
`timescale 1ns / 1ps

module rcdc_window_cell import rcdc_pkg::*; #(
  parameter logic [7:0] SEED = 8'h00
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  win_ctrl_t ctrl_i,
  input  logic [7:0] prev_i,
  output logic [7:0] byte_o
);

  logic [7:0] byte_q, byte_d;

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.init) begin
      byte_d = SEED;
    end else if (ctrl_i.shift) begin
      byte_d = prev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= SEED;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

>>> rtl/rcdc_fp_unit.sv
// rolling fingerprint register with slide-out and reduction tables
`timescale 1ns / 1ps

module rcdc_fp_unit import rcdc_pkg::*; #(
  parameter int unsigned WINDOW_SIZE = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  win_ctrl_t  ctrl_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] next_leave_i,
  output fp_t        fp_step_o
);

  localparam fp_rom_t SlideRom = build_slide_rom(WINDOW_SIZE);

  fp_t fp_q, fp_d;
  fp_t slide_q, slide_d;
  fp_t fp_x;
  logic [7:0] top;

  // remove the leaving byte, then shift the new byte in and fold the top
  always_comb begin
    fp_x      = fp_q ^ slide_q;
    top       = fp_x[FP_W-1 -: 8];
    fp_step_o = {fp_x[FP_W-9:0], byte_i} ^ REDUCE_ROM[top];
  end

  always_comb begin
    fp_d    = fp_q;
    slide_d = slide_q;
    if (ctrl_i.init) begin
      fp_d    = FP_SEED;
      slide_d = SlideRom[0];
    end else if (ctrl_i.shift) begin
      fp_d    = fp_step_o;
      slide_d = SlideRom[next_leave_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fp_q    <= FP_SEED;
      slide_q <= SlideRom[0];
    end else begin
      fp_q    <= fp_d;
      slide_q <= slide_d;
    end
  end

endmodule
